>>> hdl/assert_macros.svh
// Assertion macros used by the RTL core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// ante true at an edge implies cons at the same edge
`define JADM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: assertion failed");
// ante true at an edge implies cons at the next edge
`define JADM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: assertion failed");
`else
`define JADM_ASSERT_IMPL(lbl, ante, cons)
`define JADM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> hdl/jadm_pkg.sv
// Constants, widths and tables of the joystick angle drive mixer.
package jadm_pkg;

  localparam int CORDIC_STAGES = 16;  // 8..24
  localparam int ANGLE_BITS    = 16;  // 10..24

  localparam int STICK_W  = 8;
  localparam int SPEED_W  = 8;
  localparam int SCALE_SH = 16;               // stick scaled by 2^16
  localparam int CW       = 27;               // CORDIC re/im width
  localparam int ZW       = 32;               // turn accumulator width
  localparam int FRAC_W   = ANGLE_BITS - 3;   // in-sector fraction
  localparam int TAB_W    = 5;                // table entry, tenths
  localparam int DIFF_W   = TAB_W + 1;
  localparam int PROD_W   = DIFF_W + FRAC_W + 1;
  localparam int NUM_W    = FRAC_W + 9;

  localparam logic [ZW-1:0] HALF_TURN = 32'h8000_0000;

  // atan(2^-i) in 2^32 turn units
  function automatic logic [ZW-1:0] atan_turn(input logic [4:0] i);
    logic [ZW-1:0] r;
    unique case (i)
      5'd0:    r = 32'h20000000;
      5'd1:    r = 32'h12E4051E;
      5'd2:    r = 32'h09FB385B;
      5'd3:    r = 32'h051111D4;
      5'd4:    r = 32'h028B0D43;
      5'd5:    r = 32'h0145D7E1;
      5'd6:    r = 32'h00A2F61E;
      5'd7:    r = 32'h00517C55;
      5'd8:    r = 32'h0028BE53;
      5'd9:    r = 32'h00145F2F;
      5'd10:   r = 32'h000A2F98;
      5'd11:   r = 32'h000517CC;
      5'd12:   r = 32'h00028BE6;
      5'd13:   r = 32'h000145F3;
      5'd14:   r = 32'h0000A2FA;
      5'd15:   r = 32'h0000517D;
      5'd16:   r = 32'h000028BE;
      5'd17:   r = 32'h0000145F;
      5'd18:   r = 32'h00000A30;
      5'd19:   r = 32'h00000518;
      5'd20:   r = 32'h0000028C;
      5'd21:   r = 32'h00000146;
      5'd22:   r = 32'h000000A3;
      5'd23:   r = 32'h00000051;
      default: r = '0;
    endcase
    return r;
  endfunction

  // left wheel table, tenths, reverse direction
  function automatic logic signed [TAB_W-1:0] left_tenths(input logic [3:0] idx);
    logic signed [TAB_W-1:0] r;
    unique case (idx)
      4'd0, 4'd1, 4'd2:             r = 5'sd10;
      4'd3:                         r = 5'sd7;
      4'd5:                         r = -5'sd7;
      4'd4, 4'd6, 4'd7, 4'd8:       r = -5'sd10;
      default:                      r = '0;
    endcase
    return r;
  endfunction

  // right wheel table, tenths
  function automatic logic signed [TAB_W-1:0] right_tenths(input logic [3:0] idx);
    logic signed [TAB_W-1:0] r;
    unique case (idx)
      4'd1:                         r = 5'sd7;
      4'd2, 4'd3, 4'd4:             r = 5'sd10;
      4'd7:                         r = -5'sd7;
      4'd0, 4'd5, 4'd6, 4'd8:       r = -5'sd10;
      default:                      r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/joystick_angle_drive_mixer_core.sv
// Joystick angle drive mixer: pipelined CORDIC angle plus wheel speed interpolation.
// One joystick sample (x, y) per item goes in; one item with the right and left
// wheel speeds in whole percent comes out. The compass angle atan2(x, y), measured
// from +y toward +x and folded into one turn, is found by a fully pipelined
// CORDIC vectoring engine, one register stage per micro-rotation; a zero stick
// gives angle 0. The top three angle bits pick a 45-degree sector, the rest is
// the fraction used to interpolate between two nine-point speed tables, and the
// result is rounded to nearest, ties away from zero. Rate: one item per cycle.
// There are CORDIC_STAGES + 4 register stages (20 as built): an input register,
// one stage per CORDIC iteration, a multiply stage, a scaling stage and the
// rounding/output register. The whole pipeline advances together; it freezes
// only while the output register holds an item that the sink does not take,
// so s_axis_tready is low only in that case. left_speed is the speed applied
// in reverse direction.
`include "assert_macros.svh"

module joystick_angle_drive_mixer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] stick_x, [15:8] stick_y (signed)
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [7:0] right_speed, [15:8] left_speed (signed)
);
  import jadm_pkg::*;

  localparam int NS = CORDIC_STAGES;  // last CORDIC register index

  // output word of a zero stick: right -100, left +100
  localparam logic [2*SPEED_W-1:0] ZERO_STICK_TDATA = {8'sd100, -8'sd100};

  // pipeline advance: output empty or being taken
  logic adv;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // ---------------------------------------------------------------
  // Input stage: pre-rotate into the right half plane
  // ---------------------------------------------------------------
  logic signed [STICK_W-1:0] stick_x, stick_y;
  logic signed [CW-1:0]      xs, ys;
  logic signed [CW-1:0]      re_in, im_in;
  logic [ZW-1:0]             z_in;
  logic                      zero_in;

  assign stick_x = s_axis_tdata[STICK_W-1:0];
  assign stick_y = s_axis_tdata[2*STICK_W-1:STICK_W];

  always_comb begin
    xs      = CW'(stick_x) <<< SCALE_SH;
    ys      = CW'(stick_y) <<< SCALE_SH;
    zero_in = (stick_x == '0) && (stick_y == '0);
    if (stick_y < 0) begin
      re_in = -ys;
      im_in = -xs;
      z_in  = HALF_TURN;
    end else begin
      re_in = ys;
      im_in = xs;
      z_in  = '0;
    end
  end

  // ---------------------------------------------------------------
  // CORDIC stages, index 0 is the input register
  // ---------------------------------------------------------------
  logic                 vld_q  [0:NS];
  logic                 zero_q [0:NS];
  logic signed [CW-1:0] re_q   [0:NS];
  logic signed [CW-1:0] im_q   [0:NS];
  logic [ZW-1:0]        z_q    [0:NS];

  logic signed [CW-1:0] re_d   [1:NS];
  logic signed [CW-1:0] im_d   [1:NS];
  logic [ZW-1:0]        z_d    [1:NS];

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      if (!im_q[k][CW-1]) begin
        re_d[k+1] = re_q[k] + (im_q[k] >>> k);
        im_d[k+1] = im_q[k] - (re_q[k] >>> k);
        z_d[k+1]  = z_q[k] + atan_turn(5'(k));
      end else begin
        re_d[k+1] = re_q[k] - (im_q[k] >>> k);
        im_d[k+1] = im_q[k] + (re_q[k] >>> k);
        z_d[k+1]  = z_q[k] - atan_turn(5'(k));
      end
    end
  end

  // ---------------------------------------------------------------
  // Multiply stage: sector lookup and slope times fraction
  // ---------------------------------------------------------------
  logic [ANGLE_BITS-1:0]       ang;
  logic [3:0]                  sector;
  logic [FRAC_W-1:0]           frac;
  logic signed [TAB_W-1:0]     ra, la;
  logic signed [DIFF_W-1:0]    rdif, ldif;
  logic signed [PROD_W-1:0]    rprod_d, lprod_d;

  always_comb begin
    ang     = zero_q[NS] ? '0 : z_q[NS][ZW-1 -: ANGLE_BITS];
    sector  = {1'b0, ang[ANGLE_BITS-1 -: 3]};
    frac    = ang[FRAC_W-1:0];
    ra      = right_tenths(sector);
    la      = left_tenths(sector);
    rdif    = DIFF_W'(right_tenths(sector + 4'd1)) - DIFF_W'(ra);
    ldif    = DIFF_W'(left_tenths(sector + 4'd1)) - DIFF_W'(la);
    rprod_d = PROD_W'(rdif) * $signed({1'b0, frac});
    lprod_d = PROD_W'(ldif) * $signed({1'b0, frac});
  end

  logic                    m_vld_q, m_zero_q;
  logic signed [TAB_W-1:0] ra_q, la_q;
  logic signed [PROD_W-1:0] rprod_q, lprod_q;

  // ---------------------------------------------------------------
  // Scaling stage: 10 * (a * 2^F + prod)
  // ---------------------------------------------------------------
  function automatic logic signed [NUM_W-1:0] scale_num(
    input logic signed [TAB_W-1:0]  a,
    input logic signed [PROD_W-1:0] p
  );
    logic signed [NUM_W-1:0] sum;
    sum = (NUM_W'(a) <<< FRAC_W) + NUM_W'(p);
    return (sum <<< 3) + (sum <<< 1);
  endfunction

  logic signed [NUM_W-1:0] rnum_d, lnum_d;
  logic signed [NUM_W-1:0] rnum_q, lnum_q;
  logic                    n_vld_q, n_zero_q;

  assign rnum_d = scale_num(ra_q, rprod_q);
  assign lnum_d = scale_num(la_q, lprod_q);

  // ---------------------------------------------------------------
  // Rounding stage: drop F bits, round to nearest, ties away from zero
  // ---------------------------------------------------------------
  // negative values take half - 1 so the floor lands away from zero on a tie
  function automatic logic signed [SPEED_W-1:0] round_speed(
    input logic signed [NUM_W-1:0] num
  );
    logic signed [NUM_W-1:0] half, bias, q;
    half = NUM_W'(1) <<< (FRAC_W - 1);
    bias = num[NUM_W-1] ? (half - NUM_W'(1)) : half;
    q    = (num + bias) >>> FRAC_W;
    return SPEED_W'(q);
  endfunction

  logic signed [SPEED_W-1:0] right_d, left_d;
  logic signed [SPEED_W-1:0] right_q, left_q;
  logic                      out_vld_q, out_zero_q;

  assign right_d = round_speed(rnum_q);
  assign left_d  = round_speed(lnum_q);

  // ---------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= NS; k++) vld_q[k] <= 1'b0;
      m_vld_q   <= 1'b0;
      n_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= s_axis_tvalid;
      for (int k = 0; k < NS; k++) vld_q[k+1] <= vld_q[k];
      m_vld_q   <= vld_q[NS];
      n_vld_q   <= m_vld_q;
      out_vld_q <= n_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      re_q[0]   <= re_in;
      im_q[0]   <= im_in;
      z_q[0]    <= z_in;
      zero_q[0] <= zero_in;
      for (int k = 1; k <= NS; k++) begin
        re_q[k]   <= re_d[k];
        im_q[k]   <= im_d[k];
        z_q[k]    <= z_d[k];
        zero_q[k] <= zero_q[k-1];
      end
      ra_q       <= ra;
      la_q       <= la;
      rprod_q    <= rprod_d;
      lprod_q    <= lprod_d;
      m_zero_q   <= zero_q[NS];
      rnum_q     <= rnum_d;
      lnum_q     <= lnum_d;
      n_zero_q   <= m_zero_q;
      right_q    <= right_d;
      left_q     <= left_d;
      out_zero_q <= n_zero_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {left_q, right_q};

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  function automatic logic speed_ok(input logic signed [SPEED_W-1:0] s);
    return (s >= -8'sd100) && (s <= 8'sd100);
  endfunction

  `JADM_ASSERT_IMPL(a_speed_range, m_axis_tvalid, speed_ok(right_q) && speed_ok(left_q))
  `JADM_ASSERT_IMPL(a_zero_stick, m_axis_tvalid && out_zero_q, m_axis_tdata == ZERO_STICK_TDATA)
  `JADM_ASSERT_NEXT(a_no_drop, vld_q[0] && adv, vld_q[1])
  `JADM_ASSERT_IMPL(a_stall_blocks, m_axis_tvalid && !m_axis_tready, !s_axis_tready)

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the joystick angle drive mixer core.
module testbench;

  localparam int STAGES   = jadm_pkg::CORDIC_STAGES;
  localparam int ABITS    = jadm_pkg::ANGLE_BITS;
  localparam int FBITS    = ABITS - 3;
  localparam int LATENCY  = STAGES + 3;
  localparam int N_RANDOM = 1030;

  typedef struct packed {
    logic       hold_drain;  // sender waits until all results are back
    logic [7:0] y;
    logic [7:0] x;
  } stick_sample_t;

  typedef struct packed {
    logic [7:0] left;
    logic [7:0] right;
  } wheel_pair_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  joystick_angle_drive_mixer_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] stick_x, [15:8] stick_y
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)    // [7:0] right_speed, [15:8] left_speed
  );

  always #5 clk_i = ~clk_i;

  stick_sample_t samples_pending[$];
  wheel_pair_t   wheel_speeds_due[$];
  int            error_count = 0;

  // ---------------------------------------------------------------- predictor

  // atan(2^-i) as a fraction of 2^32 per full turn
  function automatic logic [31:0] rotation_turn(input int i);
    case (i)
      0:  return 32'h20000000;  1:  return 32'h12E4051E;
      2:  return 32'h09FB385B;  3:  return 32'h051111D4;
      4:  return 32'h028B0D43;  5:  return 32'h0145D7E1;
      6:  return 32'h00A2F61E;  7:  return 32'h00517C55;
      8:  return 32'h0028BE53;  9:  return 32'h00145F2F;
      10: return 32'h000A2F98;  11: return 32'h000517CC;
      12: return 32'h00028BE6;  13: return 32'h000145F3;
      14: return 32'h0000A2FA;  15: return 32'h0000517D;
      16: return 32'h000028BE;  17: return 32'h0000145F;
      18: return 32'h00000A30;  19: return 32'h00000518;
      20: return 32'h0000028C;  21: return 32'h00000146;
      22: return 32'h000000A3;  23: return 32'h00000051;
      default: return 32'h0;
    endcase
  endfunction

  // speed tables in tenths, nine points around the compass
  function automatic longint wheel_tenths(input bit is_left, input int idx);
    longint lt [9];
    longint rt [9];
    lt = '{10, 10, 10, 7, -10, -7, -10, -10, -10};
    rt = '{-10, 7, 10, 10, 10, -10, -10, -7, -10};
    return is_left ? lt[idx] : rt[idx];
  endfunction

  // linear blend between sector and sector+1, rounded half away from zero
  function automatic logic [7:0] blend_speed(input bit is_left, input int sector,
                                             input longint frac);
    longint a, b, num, half;
    a    = wheel_tenths(is_left, sector);
    b    = wheel_tenths(is_left, sector + 1);
    num  = 10 * (a * (64'sd1 <<< FBITS) + (b - a) * frac);
    half = 64'sd1 <<< (FBITS - 1);
    if (num >= 0) return 8'((num + half) >>> FBITS);
    return 8'(-((-num + half) >>> FBITS));
  endfunction

  function automatic wheel_pair_t mix_wheels(input logic signed [7:0] x,
                                             input logic signed [7:0] y);
    longint      re, im, d_re, d_im, frac;
    logic [31:0] z, ang;
    int          sector;
    wheel_pair_t w;
    re = longint'(y) * 65536;
    im = longint'(x) * 65536;
    z  = '0;
    // zero stick keeps angle 0
    if (x != 0 || y != 0) begin
      if (re < 0) begin
        re = -re;
        im = -im;
        z  = 32'h8000_0000;
      end
      for (int i = 0; i < STAGES && i < 24; i++) begin
        d_re = im >>> i;
        d_im = re >>> i;
        if (im >= 0) begin
          re += d_re;
          im -= d_im;
          z  += rotation_turn(i);
        end else begin
          re -= d_re;
          im += d_im;
          z  -= rotation_turn(i);
        end
      end
    end
    ang    = z >> (32 - ABITS);
    sector = int'(ang >> FBITS) & 7;
    frac   = longint'(ang & ((32'd1 << FBITS) - 1));
    w.right = blend_speed(1'b0, sector, frac);
    w.left  = blend_speed(1'b1, sector, frac);
    return w;
  endfunction

  // ----------------------------------------------------------------- idling

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // ----------------------------------------------------------------- driver

  stick_sample_t cur_sample;
  int            send_gap = 0;
  bit            send_calm = 1'b0;
  logic          send_valid_nxt;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      send_gap = 0;
    end else begin
      if ($urandom_range(0, 127) == 0) send_calm = !send_calm;
      send_valid_nxt = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        wheel_speeds_due.push_back(mix_wheels(cur_sample.x, cur_sample.y));
        send_valid_nxt = 1'b0;
        send_gap = send_calm ? 0 : pick_gap();
      end
      if (!send_valid_nxt) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (samples_pending.size() > 0 &&
                     !(samples_pending[0].hold_drain && wheel_speeds_due.size() > 0)) begin
          cur_sample = samples_pending.pop_front();
          send_valid_nxt = 1'b1;
          s_axis_tdata <= {cur_sample.y, cur_sample.x};
        end
      end
      s_axis_tvalid <= send_valid_nxt;
    end
  end

  // ---------------------------------------------------------------- monitor

  int          sink_stall = 0;
  bit          sink_calm = 1'b0;
  wheel_pair_t got, want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_stall = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (wheel_speeds_due.size() == 0) begin
          $error("result with nothing expected: %h", m_axis_tdata);
          error_count++;
        end else begin
          want = wheel_speeds_due.pop_front();
          if (got.right !== want.right) begin
            $error("right_speed mismatch: expected %0d, got %0d",
                   $signed(want.right), $signed(got.right));
            error_count++;
          end
          if (got.left !== want.left) begin
            $error("left_speed mismatch: expected %0d, got %0d",
                   $signed(want.left), $signed(got.left));
            error_count++;
          end
        end
      end
      if ($urandom_range(0, 127) == 0) sink_calm = !sink_calm;
      if (sink_stall > 0) begin
        sink_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        sink_stall = sink_calm ? 0 : pick_gap();
      end
    end
  end

  // --------------------------------------------------------------- stimulus

  task automatic queue_sample(input int x, input int y, input bit drain = 1'b0);
    stick_sample_t s;
    s.x = 8'(x);
    s.y = 8'(y);
    s.hold_drain = drain;
    samples_pending.push_back(s);
  endtask

  initial begin
    int r, x, y;
    // zero stick, corners, axes, the -128 codes
    queue_sample(0, 0);
    queue_sample(127, 127);     queue_sample(-127, -127);
    queue_sample(127, -127);    queue_sample(-127, 127);
    queue_sample(-128, -128);   queue_sample(-128, 127);
    queue_sample(127, -128);    queue_sample(0, -128);
    queue_sample(-128, 0);
    queue_sample(0, 127);       queue_sample(127, 0);
    queue_sample(0, -127);      queue_sample(-127, 0);
    queue_sample(1, 0);         queue_sample(0, 1);
    queue_sample(-1, 0);        queue_sample(0, -1);
    queue_sample(1, 1);         queue_sample(-1, -1);
    // just short of a full turn, and either side of the half turn
    queue_sample(-1, 127);      queue_sample(-1, 1);
    queue_sample(-1, -128);     queue_sample(1, -128);
    for (int i = 0; i < N_RANDOM; i++) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        x = $urandom_range(0, 255);
        y = $urandom_range(0, 255);
      end else if (r < 88) begin
        // near the origin and the axes
        x = $urandom_range(0, 6) - 3;
        y = $urandom_range(0, 255);
        if ($urandom_range(0, 1)) begin
          r = x; x = y; y = r;
        end
      end else begin
        // close to the wrap at a full turn
        x = -$urandom_range(0, 6);
        y = $urandom_range(64, 127);
      end
      queue_sample(x, y, (i % 300) == 0);
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (samples_pending.size() > 0 || s_axis_tvalid) @(posedge clk_i);
    while (wheel_speeds_due.size() > 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("[joystick_angle_drive_mixer_core] OK");
    end else begin
      $display("[joystick_angle_drive_mixer_core] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("[joystick_angle_drive_mixer_core] ERROR");
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/jadm_pkg.sv
hdl/joystick_angle_drive_mixer_core.sv
tb/testbench.sv
